>>> src/blmav_pkg.sv
// Shared constants, types and level functions for the band level moving average unit.
`timescale 1ns / 1ps

package blmav_pkg;

  localparam int READINGS_DEFAULT = 8;
  localparam int BANDS_DEFAULT = 7;

  localparam int LEVEL_W = 8;
  localparam int SAMPLE_W = 10;
  localparam int BAND_W = 3;
  localparam int MODE_W = 2;

  localparam int RESULT_DEPTH = 4;
  localparam int RESULT_PTR_W = 2;
  localparam int RESULT_CNT_W = 3;

  localparam logic [MODE_W-1:0] MODE_LEFT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;

  typedef struct packed {
    logic [LEVEL_W-1:0] left;
    logic [LEVEL_W-1:0] right;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic              in_range;
    logic              store;
    logic [MODE_W-1:0] mode;
  } item_ctrl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mean;
    logic [LEVEL_W-1:0] latest;
  } result_t;

  function automatic logic [LEVEL_W-1:0] mix_level(input entry_t e);
    logic [LEVEL_W:0] total;
    total = {1'b0, e.left} + {1'b0, e.right};
    return total[LEVEL_W:1];
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level(input entry_t e,
                                                    input logic [MODE_W-1:0] mode);
    logic [LEVEL_W-1:0] level;
    unique case (mode)
      MODE_LEFT:  level = e.left;
      MODE_RIGHT: level = e.right;
      default:    level = mix_level(e);
    endcase
    return level;
  endfunction

endpackage

>>> src/blmav_ring.sv
// Ring entry memory with post-reset clearing sweep and write-to-read forwarding.
`timescale 1ns / 1ps

module blmav_ring #(
  parameter int DEPTH = blmav_pkg::BANDS_DEFAULT * blmav_pkg::READINGS_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  blmav_pkg::entry_t    wr_data,
  output blmav_pkg::entry_t    rd_data,
  output logic                 clearing
);

  blmav_pkg::entry_t mem [DEPTH];
  blmav_pkg::entry_t rd_q;
  blmav_pkg::entry_t fwd_data;
  logic              fwd;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      fwd <= 1'b0;
    end else begin
      fwd <= rd_en && wr_en && (wr_addr == rd_addr);
      if (clearing) begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    fwd_data <= wr_data;
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

>>> src/blmav_accum.sv
// Per-band running sums, ring write-back and selection of the reported levels.
`timescale 1ns / 1ps

module blmav_accum #(
  parameter int BANDS = blmav_pkg::BANDS_DEFAULT,
  parameter int BIDX_W = (BANDS > 1) ? $clog2(BANDS) : 1,
  parameter int SUM_W = blmav_pkg::LEVEL_W + $clog2(blmav_pkg::READINGS_DEFAULT)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  blmav_pkg::item_ctrl_t             ctrl,
  input  logic [BIDX_W-1:0]                 bidx,
  input  blmav_pkg::entry_t                 old_entry,
  input  blmav_pkg::entry_t                 new_entry,
  output logic                              wr_en,
  output logic                              s2_valid,
  output logic [SUM_W-1:0]                  s2_sum,
  output logic [blmav_pkg::LEVEL_W-1:0]     s2_latest
);

  logic [SUM_W-1:0] sum_l [BANDS];
  logic [SUM_W-1:0] sum_r [BANDS];
  logic [SUM_W-1:0] sum_m [BANDS];
  logic [SUM_W-1:0] cur_l, cur_r, cur_m;
  logic [SUM_W-1:0] upd_l, upd_r, upd_m;
  logic [SUM_W-1:0] sel_sum;
  blmav_pkg::entry_t eff;

  assign wr_en = ctrl.valid && ctrl.in_range && ctrl.store;

  always_comb begin
    cur_l = '0;
    cur_r = '0;
    cur_m = '0;
    if (ctrl.in_range) begin
      cur_l = sum_l[bidx];
      cur_r = sum_r[bidx];
      cur_m = sum_m[bidx];
    end
    eff = ctrl.store ? new_entry : old_entry;
    upd_l = cur_l;
    upd_r = cur_r;
    upd_m = cur_m;
    if (ctrl.store) begin
      upd_l = cur_l - SUM_W'(old_entry.left) + SUM_W'(new_entry.left);
      upd_r = cur_r - SUM_W'(old_entry.right) + SUM_W'(new_entry.right);
      upd_m = cur_m - SUM_W'(blmav_pkg::mix_level(old_entry))
            + SUM_W'(blmav_pkg::mix_level(new_entry));
    end
    unique case (ctrl.mode)
      blmav_pkg::MODE_LEFT:  sel_sum = upd_l;
      blmav_pkg::MODE_RIGHT: sel_sum = upd_r;
      default:               sel_sum = upd_m;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BANDS; b++) begin
        sum_l[b] <= '0;
        sum_r[b] <= '0;
        sum_m[b] <= '0;
      end
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= ctrl.valid;
      if (wr_en) begin
        sum_l[bidx] <= upd_l;
        sum_r[bidx] <= upd_r;
        sum_m[bidx] <= upd_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_sum <= ctrl.in_range ? sel_sum : '0;
    s2_latest <= ctrl.in_range ? blmav_pkg::pick_level(eff, ctrl.mode) : '0;
  end

endmodule

>>> src/blmav_scale.sv
// Reciprocal scaling of the band sum to its mean and the result queue.
`timescale 1ns / 1ps

module blmav_scale #(
  parameter int READINGS = blmav_pkg::READINGS_DEFAULT,
  parameter int SUM_W = blmav_pkg::LEVEL_W + $clog2(READINGS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s2_valid,
  input  logic [SUM_W-1:0]                  s2_sum,
  input  logic [blmav_pkg::LEVEL_W-1:0]     s2_latest,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [blmav_pkg::LEVEL_W-1:0]     mean_level,
  output logic [blmav_pkg::LEVEL_W-1:0]     latest_level
);

  localparam int SHIFT = SUM_W + $clog2(READINGS);
  localparam int MULT_W = SUM_W + 2;
  localparam int PROD_W = SUM_W + MULT_W;
  localparam longint MULT = ((longint'(1) << SHIFT) + READINGS - 1) / READINGS;
  localparam int RESULT_CNT_W = blmav_pkg::RESULT_CNT_W;

  blmav_pkg::result_t                       queue [blmav_pkg::RESULT_DEPTH];
  logic [blmav_pkg::RESULT_PTR_W-1:0]       wr_ptr;
  logic [blmav_pkg::RESULT_PTR_W-1:0]       rd_ptr;
  logic [blmav_pkg::RESULT_CNT_W-1:0]       count;
  logic [PROD_W-1:0]                        prod;
  logic                                     pop;

  assign prod = PROD_W'(s2_sum) * PROD_W'(MULT);
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RESULT_CNT_W'(s2_valid) - RESULT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      queue[wr_ptr].mean <= prod[SHIFT +: blmav_pkg::LEVEL_W];
      queue[wr_ptr].latest <= s2_latest;
    end
  end

  assign out_valid = (count != '0);
  assign mean_level = queue[rd_ptr].mean;
  assign latest_level = queue[rd_ptr].latest;

endmodule

>>> src/band_level_moving_average_unit.sv
// Top level of the band level moving average unit.
`timescale 1ns / 1ps

// One beat is accepted per clock cycle while in_ready is high; its result is
// registered in turn by the ring memory read, the running-sum update and the
// reciprocal multiply that forms the mean, written into the result queue. Up to
// four beats may be outstanding; the input is held off once four results are
// in flight or waiting. After reset the ring memory is swept clear, one entry
// per cycle, so no input is taken until the sweep is done. Each band keeps
// running left, right and mixed sums, so the mean costs no pass over the ring.
module band_level_moving_average_unit #(
  parameter int READINGS = blmav_pkg::READINGS_DEFAULT,
  parameter int BANDS = blmav_pkg::BANDS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [blmav_pkg::BAND_W-1:0]       band,
  input  logic                               store,
  input  logic [blmav_pkg::SAMPLE_W-1:0]     left_sample,
  input  logic [blmav_pkg::SAMPLE_W-1:0]     right_sample,
  input  logic [blmav_pkg::MODE_W-1:0]       mix_mode,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [blmav_pkg::LEVEL_W-1:0]      mean_level,
  output logic [blmav_pkg::LEVEL_W-1:0]      latest_level
);

  localparam int DEPTH = BANDS * READINGS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W = (READINGS > 1) ? $clog2(READINGS) : 1;
  localparam int BIDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int SUM_W = blmav_pkg::LEVEL_W + $clog2(READINGS);
  localparam int CNT_W = blmav_pkg::RESULT_CNT_W;

  logic                              accept;
  logic                              out_accept;
  logic                              clearing;
  logic [4:0]                        band_ext;
  logic                              in_range;
  logic [BIDX_W-1:0]                 bidx;
  logic [SLOT_W-1:0]                 slot;
  logic [SLOT_W-1:0]                 slot_next;
  logic [SLOT_W-1:0]                 slot_adv;
  logic                              advance;
  logic [ADDR_W-1:0]                 addr;
  logic [CNT_W-1:0]                  inflight;

  blmav_pkg::item_ctrl_t             s1_ctrl;
  logic [BIDX_W-1:0]                 s1_bidx;
  logic [ADDR_W-1:0]                 s1_addr;
  blmav_pkg::entry_t                 s1_entry;
  blmav_pkg::entry_t                 old_entry;
  logic                              wr_en;
  logic                              s2_valid;
  logic [SUM_W-1:0]                  s2_sum;
  logic [blmav_pkg::LEVEL_W-1:0]     s2_latest;

  assign in_ready = !clearing && (inflight < CNT_W'(blmav_pkg::RESULT_DEPTH));
  assign accept = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  assign band_ext = {2'b00, band};
  assign in_range = band_ext < 5'(BANDS);
  assign bidx = band_ext[BIDX_W-1:0];

  assign slot_adv = (slot == SLOT_W'(READINGS - 1)) ? '0 : slot + 1'b1;
  assign advance = accept && in_range && store && (band == '0);
  assign slot_next = advance ? slot_adv : slot;
  assign addr = ADDR_W'(ADDR_W'(bidx) * ADDR_W'(READINGS)) + ADDR_W'(slot_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      inflight <= '0;
      s1_ctrl <= '0;
    end else begin
      slot <= slot_next;
      inflight <= inflight + CNT_W'(accept) - CNT_W'(out_accept);
      s1_ctrl.valid <= accept;
      s1_ctrl.in_range <= in_range;
      s1_ctrl.store <= store;
      s1_ctrl.mode <= mix_mode;
    end
  end

  always_ff @(posedge clk) begin
    s1_bidx <= bidx;
    s1_addr <= addr;
    s1_entry.left <= left_sample[blmav_pkg::SAMPLE_W-1 -: blmav_pkg::LEVEL_W];
    s1_entry.right <= right_sample[blmav_pkg::SAMPLE_W-1 -: blmav_pkg::LEVEL_W];
  end

  blmav_ring #(
    .DEPTH(DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ring (
    .clk(clk),
    .rst(rst),
    .rd_en(accept && in_range),
    .rd_addr(addr),
    .wr_en(wr_en),
    .wr_addr(s1_addr),
    .wr_data(s1_entry),
    .rd_data(old_entry),
    .clearing(clearing)
  );

  blmav_accum #(
    .BANDS(BANDS),
    .BIDX_W(BIDX_W),
    .SUM_W(SUM_W)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .ctrl(s1_ctrl),
    .bidx(s1_bidx),
    .old_entry(old_entry),
    .new_entry(s1_entry),
    .wr_en(wr_en),
    .s2_valid(s2_valid),
    .s2_sum(s2_sum),
    .s2_latest(s2_latest)
  );

  blmav_scale #(
    .READINGS(READINGS),
    .SUM_W(SUM_W)
  ) u_scale (
    .clk(clk),
    .rst(rst),
    .s2_valid(s2_valid),
    .s2_sum(s2_sum),
    .s2_latest(s2_latest),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mean_level(mean_level),
    .latest_level(latest_level)
  );

  assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(blmav_pkg::RESULT_DEPTH))
    else $error("More beats outstanding than the result queue can hold.");

  assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(READINGS - 1))
    else $error("Write slot has run past the ring length.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inflight != '0))
    else $error("Result offered with no beat outstanding.");

  assert property (@(posedge clk) disable iff (rst)
    (advance && (READINGS > 1)) |=> (slot != $past(slot)))
    else $error("Band zero store did not advance the write slot.");

endmodule
